/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define APC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the next cycle
`define APC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/apc_pkg.sv */
// ---------------------------------------------------------------------------
// Angle PID controller package
// Widths, fixed-point constants and shared types.
// ---------------------------------------------------------------------------
package apc_pkg;

   localparam int ANGLE_FRAC_BITS = 6;
   localparam int ANGLE_W         = 15;
   localparam int GAIN_W          = 24;
   localparam int LIMIT_W         = 16;
   localparam int IDX_W           = 3;
   localparam int DEN_W           = GAIN_W + 2;
   localparam int DIV_BITS        = 60;
   localparam int DIV_CNT_W       = $clog2(DIV_BITS);
   localparam int MUL_A_W         = 25;
   localparam int MUL_B_W         = 27;
   localparam int PROD_W          = MUL_A_W + MUL_B_W;
   localparam int ACC_W           = 48;

   localparam logic signed [16:0] HALF_TURN  = 17'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [16:0] FULL_TURN  = 17'(360 << ANGLE_FRAC_BITS);
   localparam logic signed [16:0] WRAP_LIMIT = 17'(300 << ANGLE_FRAC_BITS);

   localparam logic [IDX_W-1:0] REG_KP      = 3'd0;
   localparam logic [IDX_W-1:0] REG_KI      = 3'd1;
   localparam logic [IDX_W-1:0] REG_KD      = 3'd2;
   localparam logic [IDX_W-1:0] REG_TS      = 3'd3;
   localparam logic [IDX_W-1:0] REG_TAU     = 3'd4;
   localparam logic [IDX_W-1:0] REG_OUT_MAX = 3'd5;
   localparam logic [IDX_W-1:0] REG_OUT_MIN = 3'd6;

   localparam logic [GAIN_W-1:0]         TS_RESET      = 24'd67109;
   localparam logic [GAIN_W-1:0]         TAU_RESET     = 24'd1677722;
   localparam logic signed [LIMIT_W-1:0] OUT_MAX_RESET = 16'sd1000;
   localparam logic signed [LIMIT_W-1:0] OUT_MIN_RESET = -16'sd1000;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* sv/apc_mul.sv */
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 25 x 27 multiply with a registered product, held when not issued.
// ---------------------------------------------------------------------------
module apc_mul import apc_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [MUL_A_W-1:0] a,
   input  logic signed [MUL_B_W-1:0] b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = en ? PROD_W'(a * b) : prod_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* sv/apc_div.sv */
// ---------------------------------------------------------------------------
// Shared divider
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module apc_div import apc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [DEN_W-1:0]    divisor,
   output logic [DIV_BITS-1:0] quotient,
   output div_status_type      status
);

   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       trial_sub;
   logic                 ge;

   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_BITS-1]};
      trial_sub = trial - {1'b0, divisor};
      ge        = trial >= {1'b0, divisor};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* sv/angle_pid_controller.sv */
// ---------------------------------------------------------------------------
// Angle PID controller
// PID on a wrapped angle error: trapezoidal integral, filtered derivative on
// measurement, saturating Q32.16 accumulators and a clamped drive output.
// ---------------------------------------------------------------------------
// One transaction is taken at a time. A restart transaction goes from
// acceptance straight to the output state. A normal transaction runs two
// 60-step divisions in the shared radix-2 divider (the filter coefficient,
// then the derivative input term); with a zero filter denominator no
// division runs. A finished result sits in the output register while the
// next transaction is accepted.
module angle_pid_controller import apc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,  // measured_angle[14:0], target_angle[29:15]
   input  logic               req_tuser,  // restart
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,  // drive[15:0]
   input  logic               csr_we,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [GAIN_W-1:0]  csr_wdata
);

`include "assert_macros.svh"

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_P    = 4'd1;
   localparam logic [3:0] ST_G    = 4'd2;
   localparam logic [3:0] ST_GL   = 4'd3;
   localparam logic [3:0] ST_GH   = 4'd4;
   localparam logic [3:0] ST_IACC = 4'd5;
   localparam logic [3:0] ST_WC   = 4'd6;
   localparam logic [3:0] ST_ML   = 4'd7;
   localparam logic [3:0] ST_MH   = 4'd8;
   localparam logic [3:0] ST_MSUM = 4'd9;
   localparam logic [3:0] ST_WB   = 4'd10;
   localparam logic [3:0] ST_TOT  = 4'd11;

   localparam int P_W   = PROD_W - ANGLE_FRAC_BITS;
   localparam int SUM_W = 52;

   function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) begin
         sat48 = hi[ACC_W-1:0];
      end else if (v < lo) begin
         sat48 = lo[ACC_W-1:0];
      end else begin
         sat48 = v[ACC_W-1:0];
      end
   endfunction

   // configuration
   logic [GAIN_W-1:0]         kp_ff, ki_ff, kd_ff, ts_ff, tau_ff;
   logic signed [LIMIT_W-1:0] out_max_ff, out_min_ff;

   // state and working registers
   logic [3:0]                 state_ff, state_in;
   logic [ANGLE_W-1:0]         prev_angle_ff;
   logic signed [15:0]         prev_err_ff;
   logic signed [ACC_W-1:0]    iacc_ff, dacc_ff;
   logic signed [15:0]         err_ff, diff_ff;
   logic signed [16:0]         sum_e_ff;
   logic                       restart_ff;
   logic signed [P_W-1:0]      p_term_ff;
   logic [31:0]                g_ff;
   logic signed [PROD_W-1:0]   prodl_ff;
   logic signed [DEN_W-1:0]    coef_ff;
   logic                       bneg_ff;
   logic signed [SUM_W-1:0]    mulres_ff;
   logic                       rsp_valid_ff;
   logic signed [LIMIT_W-1:0]  drive_ff;

   // datapath
   logic                       accept;
   logic signed [17:0]         m_s, s_s, p_s, adj, err_w, diff_w;
   logic [DEN_W-1:0]           den;
   logic signed [DEN_W-1:0]    nc;
   logic [DEN_W-1:0]           nc_mag;
   logic                       den_zero;
   logic                       mul_en;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic                       div_start;
   logic [DIV_BITS-1:0]        div_dividend, quotient;
   div_status_type             div_status;
   logic signed [SUM_W-1:0]    isum, incr, bterm, total, max_q, min_q;
   logic signed [PROD_W-1:0]   bprod_mag;
   logic [ACC_W:0]             bmag;
   logic signed [35:0]         t_hi;
   logic                       out_free;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      m_s = {3'b0, req_tdata[ANGLE_W-1:0]};
      s_s = {3'b0, req_tdata[2*ANGLE_W-1:ANGLE_W]};
      p_s = {3'b0, prev_angle_ff};
      if (m_s > s_s + 18'(HALF_TURN) && s_s < 18'(HALF_TURN)) begin
         adj = m_s - 18'(FULL_TURN);
      end else if (m_s < s_s - 18'(HALF_TURN) && s_s >= 18'(HALF_TURN)) begin
         adj = m_s + 18'(FULL_TURN);
      end else begin
         adj = m_s;
      end
      err_w  = s_s - adj;
      diff_w = m_s - p_s;
      if (diff_w > 18'(WRAP_LIMIT)) begin
         diff_w = diff_w - 18'(FULL_TURN);
      end else if (diff_w < -18'(WRAP_LIMIT)) begin
         diff_w = diff_w + 18'(FULL_TURN);
      end
   end

   always_comb begin
      den      = {1'b0, tau_ff, 1'b0} + {2'b0, ts_ff};
      nc       = $signed({1'b0, tau_ff, 1'b0}) - $signed({2'b0, ts_ff});
      nc_mag   = nc[DEN_W-1] ? DEN_W'(-nc) : nc;
      den_zero = den == '0;
   end

   apc_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   apc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      isum      = $signed({prod[27:0], 24'b0}) + SUM_W'(prodl_ff);
      incr      = isum >>> (9 + ANGLE_FRAC_BITS);
      bprod_mag = prod[PROD_W-1] ? -prod : prod;
      if (quotient >= DIV_BITS'(1) << (ACC_W - 1)) begin
         bmag = (ACC_W+1)'(1) << (ACC_W - 1);
      end else begin
         bmag = quotient[ACC_W:0];
      end
      bterm = bneg_ff ? -SUM_W'($signed({1'b0, bmag})) : SUM_W'($signed({1'b0, bmag}));
      total = SUM_W'(p_term_ff) + SUM_W'(iacc_ff) - SUM_W'(dacc_ff);
      max_q = $signed({{(SUM_W-LIMIT_W-16){out_max_ff[LIMIT_W-1]}}, out_max_ff, 16'b0});
      min_q = $signed({{(SUM_W-LIMIT_W-16){out_min_ff[LIMIT_W-1]}}, out_min_ff, 16'b0});
      t_hi  = total[SUM_W-1:16] + 36'(total[SUM_W-1] && (total[15:0] != '0));
   end

   always_comb begin
      state_in     = state_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = {{(DIV_BITS-DEN_W-24){1'b0}}, nc_mag, 24'b0};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  state_in = ST_TOT;
               end else begin
                  state_in  = ST_P;
                  div_start = !den_zero;
               end
            end
         end
         ST_P: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, kp_ff};
            mul_b    = MUL_B_W'(err_ff);
            state_in = ST_G;
         end
         ST_G: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, ki_ff};
            mul_b    = {3'b0, ts_ff};
            state_in = ST_GL;
         end
         ST_GL: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, prod[39:16]};
            mul_b    = MUL_B_W'(sum_e_ff);
            state_in = ST_GH;
         end
         ST_GH: begin
            mul_en   = 1'b1;
            mul_a    = {17'b0, g_ff[31:24]};
            mul_b    = MUL_B_W'(sum_e_ff);
            state_in = ST_IACC;
         end
         ST_IACC: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, kd_ff};
            mul_b    = MUL_B_W'(diff_ff);
            state_in = den_zero ? ST_TOT : ST_WC;
         end
         ST_WC: begin
            div_dividend = {bprod_mag[39:0], 1'b0, 18'b0, 1'b0} >> 1;
            if (div_status.done) begin
               div_start = 1'b1;
               state_in  = ST_ML;
            end
         end
         ST_ML: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, dacc_ff[23:0]};
            mul_b    = MUL_B_W'(coef_ff);
            state_in = ST_MH;
         end
         ST_MH: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'($signed(dacc_ff[ACC_W-1:24]));
            mul_b    = MUL_B_W'(coef_ff);
            state_in = ST_MSUM;
         end
         ST_MSUM: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            if (div_status.done) begin
               state_in = ST_TOT;
            end
         end
         ST_TOT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff      <= '0;
         ki_ff      <= '0;
         kd_ff      <= '0;
         ts_ff      <= TS_RESET;
         tau_ff     <= TAU_RESET;
         out_max_ff <= OUT_MAX_RESET;
         out_min_ff <= OUT_MIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_KP:      kp_ff      <= csr_wdata;
            REG_KI:      ki_ff      <= csr_wdata;
            REG_KD:      kd_ff      <= csr_wdata;
            REG_TS:      ts_ff      <= csr_wdata;
            REG_TAU:     tau_ff     <= csr_wdata;
            REG_OUT_MAX: out_max_ff <= csr_wdata[LIMIT_W-1:0];
            REG_OUT_MIN: out_min_ff <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         prev_angle_ff <= '0;
         prev_err_ff   <= '0;
         iacc_ff       <= '0;
         dacc_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_TOT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  restart_ff    <= req_tuser;
                  prev_angle_ff <= req_tdata[ANGLE_W-1:0];
                  err_ff        <= err_w[15:0];
                  diff_ff       <= diff_w[15:0];
                  sum_e_ff      <= 17'(err_w) + 17'(prev_err_ff);
                  if (req_tuser) begin
                     prev_err_ff <= '0;
                     iacc_ff     <= '0;
                     dacc_ff     <= '0;
                  end else begin
                     prev_err_ff <= err_w[15:0];
                  end
               end
            end
            ST_G:    p_term_ff <= prod[PROD_W-1:ANGLE_FRAC_BITS];
            ST_GL:   g_ff      <= prod[47:16];
            ST_GH:   prodl_ff  <= prod;
            ST_IACC: begin
               iacc_ff <= sat48(SUM_W'(iacc_ff) + incr);
               if (den_zero) begin
                  dacc_ff <= '0;
               end
            end
            ST_WC: begin
               if (div_status.done) begin
                  coef_ff <= restart_ff ? '0 :
                             (nc[DEN_W-1] ? -$signed(quotient[DEN_W-1:0])
                                          : $signed(quotient[DEN_W-1:0]));
                  bneg_ff <= prod[PROD_W-1];
               end
            end
            ST_MH:   prodl_ff  <= prod;
            ST_MSUM: mulres_ff <= SUM_W'(prod) + SUM_W'(prodl_ff >>> 24);
            ST_WB: begin
               if (div_status.done) begin
                  dacc_ff <= sat48(bterm + mulres_ff);
               end
            end
            ST_TOT: begin
               if (out_free) begin
                  if (restart_ff) begin
                     drive_ff <= '0;
                  end else if (total > max_q) begin
                     drive_ff <= out_max_ff;
                  end else if (total < min_q) begin
                     drive_ff <= out_min_ff;
                  end else begin
                     drive_ff <= t_hi[LIMIT_W-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;

   `APC_ASSERT_NEXT(a_busy_after_accept, accept, !req_tready)
   `APC_ASSERT_NEXT(a_restart_clears, accept && req_tuser, iacc_ff == '0 && dacc_ff == '0)
   `APC_ASSERT_NOW(a_div_start_idle, div_start, !div_status.busy)

endmodule
